// ----- design/bpa_pkg.sv -----
// Package for the buddy page allocator: port widths, opcodes, engine states
// and the result record passed from the engine to the output stage.
// No dependencies.
package bpa_pkg;

   localparam int OPCODE_W        = 2;
   localparam int REQUEST_BYTES_W = 25;
   localparam int NODE_INDEX_W    = 13;
   localparam int RESULT_NODE_W   = 13;
   localparam int RESULT_PAGES_W  = 13;
   localparam int BYTE_OFFSET_W   = 24;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_GROW   = 2'd2,
      OP_SHRINK = 2'd3
   } bpa_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_DESCEND,
      ST_UPDATE,
      ST_GROW_PAR,
      ST_SHRINK_R,
      ST_DONE
   } bpa_state_type;

   typedef struct packed {
      logic                      status;
      logic [RESULT_NODE_W-1:0]  result_node;
      logic [RESULT_PAGES_W-1:0] result_pages;
      logic [BYTE_OFFSET_W-1:0]  byte_offset;
   } bpa_result_type;

endpackage

// ----- design/buddy_page_allocator.sv -----
// Buddy page allocator top level: request/response handshakes, response
// register, the largest-free-block store and the sequencer.
// Depends on bpa_pkg, bpa_mem, bpa_engine.
//
//   port group   dir   handshake            contents
//   req_*        in    req_valid/req_ready  opcode, request_bytes, node_index
//   rsp_*        out   rsp_valid/rsp_ready  status, result_node, result_pages,
//                                           byte_offset
//
// Request time is bounded by one store read-modify-write per tree level, down
// and then up, through the single store. After reset a clearing pass runs with
// req_ready low. One request is in flight; the next is taken while a response
// still waits in the rsp register.
module buddy_page_allocator
   import bpa_pkg::*;
#(
   parameter int PAGE_SHIFT  = 12,
   parameter int TREE_LEVELS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic [REQUEST_BYTES_W-1:0] req_request_bytes,
   input  logic [NODE_INDEX_W-1:0]    req_node_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_status,
   output logic [RESULT_NODE_W-1:0]   rsp_result_node,
   output logic [RESULT_PAGES_W-1:0]  rsp_result_pages,
   output logic [BYTE_OFFSET_W-1:0]   rsp_byte_offset
);

   localparam int NODE_W     = TREE_LEVELS + 1;
   localparam int PAGES_W    = TREE_LEVELS + 1;
   localparam int NODE_COUNT = (1 << (TREE_LEVELS + 1)) - 1;

   logic               eng_idle;
   logic               eng_done;
   logic               start;
   logic               out_free;
   bpa_result_type     eng_result;
   logic [NODE_W-1:0]  mem_rd_addr_a;
   logic [NODE_W-1:0]  mem_rd_addr_b;
   logic [PAGES_W-1:0] mem_rd_data_a;
   logic [PAGES_W-1:0] mem_rd_data_b;
   logic               mem_wr_en;
   logic [NODE_W-1:0]  mem_wr_addr;
   logic [PAGES_W-1:0] mem_wr_data;

   logic               rsp_valid_ff, rsp_valid_in;
   bpa_result_type     rsp_data_ff, rsp_data_in;

   assign req_ready = eng_idle;
   assign start     = req_valid && eng_idle;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = eng_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_data_ff.status;
   assign rsp_result_node  = rsp_data_ff.result_node;
   assign rsp_result_pages = rsp_data_ff.result_pages;
   assign rsp_byte_offset  = rsp_data_ff.byte_offset;

   bpa_mem #(
      .DEPTH  (NODE_COUNT),
      .ADDR_W (NODE_W),
      .DATA_W (PAGES_W)
   ) u_mem (
      .clock     (clock),
      .rd_addr_a (mem_rd_addr_a),
      .rd_addr_b (mem_rd_addr_b),
      .rd_data_a (mem_rd_data_a),
      .rd_data_b (mem_rd_data_b),
      .wr_en     (mem_wr_en),
      .wr_addr   (mem_wr_addr),
      .wr_data   (mem_wr_data)
   );

   bpa_engine #(
      .PAGE_SHIFT  (PAGE_SHIFT),
      .TREE_LEVELS (TREE_LEVELS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .in_op         (bpa_op_type'(req_opcode)),
      .in_bytes      (req_request_bytes),
      .in_node       (req_node_index),
      .out_free      (out_free),
      .idle          (eng_idle),
      .done          (eng_done),
      .result        (eng_result),
      .mem_rd_addr_a (mem_rd_addr_a),
      .mem_rd_addr_b (mem_rd_addr_b),
      .mem_rd_data_a (mem_rd_data_a),
      .mem_rd_data_b (mem_rd_data_b),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data)
   );

endmodule

// ----- design/bpa_mem.sv -----
// Largest-free-block store: one write port, two registered read ports.
// A read of the address written in the same cycle returns the new data.
// Depends on nothing.
module bpa_mem #(
   parameter int DEPTH  = 8191,
   parameter int ADDR_W = 13,
   parameter int DATA_W = 13
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] ram_ff [DEPTH];
   logic [DATA_W-1:0] rdata_a_ff;
   logic [DATA_W-1:0] rdata_b_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic              hit_a_ff;
   logic              hit_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rdata_a_ff <= ram_ff[rd_addr_a];
      rdata_b_ff <= ram_ff[rd_addr_b];
      wdata_ff   <= wr_data;
      hit_a_ff   <= wr_en && (wr_addr == rd_addr_a);
      hit_b_ff   <= wr_en && (wr_addr == rd_addr_b);
   end

   assign rd_data_a = hit_a_ff ? wdata_ff : rdata_a_ff;
   assign rd_data_b = hit_b_ff ? wdata_ff : rdata_b_ff;

endmodule

// ----- design/bpa_engine.sv -----
// Allocator sequencer: clearing pass, descent, ancestor rebuild and the
// free/grow/shrink edits, all as read-modify-write steps on bpa_mem.
// Depends on bpa_pkg.
module bpa_engine
   import bpa_pkg::*;
#(
   parameter int PAGE_SHIFT  = 12,
   parameter int TREE_LEVELS = 12,
   localparam int NODE_W     = TREE_LEVELS + 1,
   localparam int PAGES_W    = TREE_LEVELS + 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  bpa_op_type                 in_op,
   input  logic [REQUEST_BYTES_W-1:0] in_bytes,
   input  logic [NODE_INDEX_W-1:0]    in_node,
   input  logic                       out_free,
   output logic                       idle,
   output logic                       done,
   output bpa_result_type             result,
   output logic [NODE_W-1:0]          mem_rd_addr_a,
   output logic [NODE_W-1:0]          mem_rd_addr_b,
   input  logic [PAGES_W-1:0]         mem_rd_data_a,
   input  logic [PAGES_W-1:0]         mem_rd_data_b,
   output logic                       mem_wr_en,
   output logic [NODE_W-1:0]          mem_wr_addr,
   output logic [PAGES_W-1:0]         mem_wr_data
);

   localparam int DEPTH_W    = $clog2(TREE_LEVELS + 1);
   localparam int NODE_COUNT = (1 << (TREE_LEVELS + 1)) - 1;
   localparam int CMP_W      = (NODE_W > NODE_INDEX_W) ? NODE_W : NODE_INDEX_W;
   localparam int SUM_W      = REQUEST_BYTES_W + 1;
   localparam int REQ_CMP_W  = (TREE_LEVELS + PAGE_SHIFT + 1 > REQUEST_BYTES_W) ?
                               (TREE_LEVELS + PAGE_SHIFT + 1) : REQUEST_BYTES_W;
   localparam int OFF_W      = NODE_W + PAGE_SHIFT + BYTE_OFFSET_W;

   localparam logic [PAGES_W-1:0]   ROOT_PAGES = PAGES_W'(1) << TREE_LEVELS;
   localparam logic [NODE_W-1:0]    LAST_NODE  = NODE_W'(NODE_COUNT - 1);
   localparam logic [DEPTH_W-1:0]   LEAF_DEPTH = DEPTH_W'(TREE_LEVELS);
   localparam logic [SUM_W-1:0]     PAGE_ROUND = SUM_W'((64'd1 << PAGE_SHIFT) - 64'd1);
   localparam logic [REQ_CMP_W-1:0] MEM_BYTES  = REQ_CMP_W'(1) << (TREE_LEVELS + PAGE_SHIFT);

   function automatic logic [PAGES_W-1:0] full_of(input logic [DEPTH_W-1:0] d);
      return ROOT_PAGES >> d;
   endfunction

   function automatic logic [DEPTH_W-1:0] depth_of(input logic [NODE_W-1:0] v);
      logic [DEPTH_W-1:0] d;
      d = '0;
      for (int i = 0; i < NODE_W; i++) begin
         if (v[i]) begin
            d = DEPTH_W'(i);
         end
      end
      return d;
   endfunction

   bpa_state_type      state_ff, state_in;
   bpa_op_type         op_ff, op_in;
   logic [PAGES_W-1:0] pages_ff, pages_in;
   logic               bad_size_ff, bad_size_in;
   logic               oor_ff, oor_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               res_status_ff, res_status_in;
   logic [NODE_W-1:0]  res_node_ff, res_node_in;
   logic [DEPTH_W-1:0] res_depth_ff, res_depth_in;

   // request decode
   logic [NODE_W-1:0]  in_node_n;
   logic [NODE_W-1:0]  in_node_p1;
   logic [SUM_W-1:0]   bytes_sum;
   logic               in_bad_size;
   logic               in_oor;

   // tree neighbors of node_ff
   logic [NODE_W-1:0]  left_kid;
   logic [NODE_W-1:0]  right_kid;
   logic [NODE_W-1:0]  parent;
   logic [NODE_W-1:0]  parent_left;
   logic [NODE_W-1:0]  chosen;
   logic [NODE_W-1:0]  chosen_left;
   logic [DEPTH_W-1:0] kid_depth;
   logic [PAGES_W-1:0] full_here;
   logic [PAGES_W-1:0] half_here;
   logic [PAGES_W-1:0] merged;
   logic [NODE_W:0]    sweep_p1;
   logic [NODE_W:0]    sweep_p2;

   // result formatting
   logic [NODE_W-1:0]  res_pos;
   logic [NODE_W-1:0]  res_page_pos;
   logic [OFF_W-1:0]   res_offset;

   assign in_node_n   = NODE_W'(in_node);
   assign in_node_p1  = in_node_n + NODE_W'(1);
   assign bytes_sum   = {1'b0, in_bytes} + PAGE_ROUND;
   assign in_bad_size = (in_bytes == '0) || (REQ_CMP_W'(in_bytes) > MEM_BYTES);
   assign in_oor      = CMP_W'(in_node) >= CMP_W'(NODE_COUNT);

   assign left_kid    = {node_ff[NODE_W-2:0], 1'b1};
   assign right_kid   = left_kid + NODE_W'(1);
   assign parent      = (node_ff - NODE_W'(1)) >> 1;
   assign parent_left = {parent[NODE_W-2:0], 1'b1};
   assign chosen      = (mem_rd_data_a >= mem_rd_data_b) ? left_kid : right_kid;
   assign chosen_left = {chosen[NODE_W-2:0], 1'b1};
   assign kid_depth   = depth_ff + DEPTH_W'(1);
   assign full_here   = full_of(depth_ff);
   assign half_here   = full_here >> 1;
   assign merged      = ((mem_rd_data_a == half_here) && (mem_rd_data_b == half_here)) ?
                        full_here :
                        ((mem_rd_data_a >= mem_rd_data_b) ? mem_rd_data_a : mem_rd_data_b);
   assign sweep_p1    = {1'b0, node_ff} + (NODE_W+1)'(1);
   assign sweep_p2    = {1'b0, node_ff} + (NODE_W+1)'(2);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pages_in      = pages_ff;
      bad_size_in   = bad_size_ff;
      oor_in        = oor_ff;
      node_in       = node_ff;
      depth_in      = depth_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_depth_in  = res_depth_ff;
      mem_rd_addr_a = left_kid;
      mem_rd_addr_b = right_kid;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = node_ff;
      mem_wr_data   = '0;
      idle          = 1'b0;
      done          = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = full_here;
            if (node_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end else begin
               node_in = sweep_p1[NODE_W-1:0];
               if ((sweep_p1 & sweep_p2) == '0) begin
                  depth_in = kid_depth;
               end
            end
         end

         ST_IDLE: begin
            idle          = 1'b1;
            mem_rd_addr_a = '0;
            mem_rd_addr_b = in_node_p1;
            if (start) begin
               op_in       = in_op;
               pages_in    = PAGES_W'(bytes_sum >> PAGE_SHIFT);
               bad_size_in = in_bad_size;
               oor_in      = in_oor;
               node_in     = in_node_n;
               depth_in    = depth_of(in_node_p1);
               state_in    = ST_START;
            end
         end

         ST_START: begin
            res_status_in = STATUS_REFUSED;
            res_node_in   = '0;
            res_depth_in  = '0;
            state_in      = ST_DONE;
            case (op_ff)
               OP_ALLOC: begin
                  if (!bad_size_ff && (mem_rd_data_a >= pages_ff)) begin
                     res_status_in = STATUS_DONE;
                     if ((ROOT_PAGES >> 1) < pages_ff) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = '0;
                     end else begin
                        node_in       = '0;
                        depth_in      = '0;
                        mem_rd_addr_a = NODE_W'(1);
                        mem_rd_addr_b = NODE_W'(2);
                        state_in      = ST_DESCEND;
                     end
                  end
               end
               OP_FREE: begin
                  if (!oor_ff) begin
                     res_status_in = STATUS_DONE;
                     res_node_in   = node_ff;
                     res_depth_in  = depth_ff;
                     mem_wr_en     = 1'b1;
                     mem_wr_data   = full_here;
                     if (node_ff != '0) begin
                        node_in       = parent;
                        depth_in      = depth_ff - DEPTH_W'(1);
                        mem_rd_addr_a = parent_left;
                        mem_rd_addr_b = parent_left + NODE_W'(1);
                        state_in      = ST_UPDATE;
                     end
                  end
               end
               OP_GROW: begin
                  if (!oor_ff && node_ff[0] && (mem_rd_data_b == full_here)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_data = full_here;
                     node_in     = parent;
                     depth_in    = depth_ff - DEPTH_W'(1);
                     state_in    = ST_GROW_PAR;
                  end
               end
               OP_SHRINK: begin
                  if (!oor_ff && (depth_ff != LEAF_DEPTH)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = left_kid;
                     state_in    = ST_SHRINK_R;
                  end
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end

         ST_DESCEND: begin
            if ((half_here >> 1) >= pages_ff) begin
               node_in       = chosen;
               depth_in      = kid_depth;
               mem_rd_addr_a = chosen_left;
               mem_rd_addr_b = chosen_left + NODE_W'(1);
            end else begin
               mem_wr_en    = 1'b1;
               mem_wr_addr  = chosen;
               res_node_in  = chosen;
               res_depth_in = kid_depth;
               state_in     = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = merged;
            if (node_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               node_in       = parent;
               depth_in      = depth_ff - DEPTH_W'(1);
               mem_rd_addr_a = parent_left;
               mem_rd_addr_b = parent_left + NODE_W'(1);
            end
         end

         ST_GROW_PAR: begin
            mem_wr_en     = 1'b1;
            res_status_in = STATUS_DONE;
            res_node_in   = node_ff;
            res_depth_in  = depth_ff;
            if (node_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               node_in       = parent;
               depth_in      = depth_ff - DEPTH_W'(1);
               mem_rd_addr_a = parent_left;
               mem_rd_addr_b = parent_left + NODE_W'(1);
               state_in      = ST_UPDATE;
            end
         end

         ST_SHRINK_R: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = right_kid;
            mem_wr_data   = half_here;
            res_status_in = STATUS_DONE;
            res_node_in   = left_kid;
            res_depth_in  = kid_depth;
            state_in      = ST_UPDATE;
         end

         ST_DONE: begin
            done = 1'b1;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         node_ff  <= '0;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pages_ff      <= pages_in;
      bad_size_ff   <= bad_size_in;
      oor_ff        <= oor_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_depth_ff  <= res_depth_in;
   end

   assign res_pos      = res_node_ff + NODE_W'(1) - (NODE_W'(1) << res_depth_ff);
   assign res_page_pos = res_pos << (LEAF_DEPTH - res_depth_ff);
   assign res_offset   = OFF_W'(res_page_pos) << PAGE_SHIFT;

   always_comb begin
      result = '0;
      result.status = res_status_ff;
      if (res_status_ff == STATUS_DONE) begin
         result.result_node  = RESULT_NODE_W'(res_node_ff);
         result.result_pages = RESULT_PAGES_W'(full_of(res_depth_ff));
         result.byte_offset  = BYTE_OFFSET_W'(res_offset);
      end
   end

endmodule

// ----- bench/buddy_page_allocator_tb.sv -----
// Self-checking bench for buddy_page_allocator: directed and random requests
// against an in-bench tree predictor, random gaps on both handshakes.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
`timescale 1ns / 100ps

module buddy_page_allocator_tb
   import bpa_pkg::*;
();

   localparam int SHIFT          = 12;
   localparam int LEVELS         = 12;
   localparam int PAGES          = 1 << LEVELS;
   localparam int NODES          = 2 * PAGES - 1;
   localparam int DRAIN_CYCLES   = 2 * LEVELS + 16;
   localparam int WATCHDOG_LIMIT = 30000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OPCODE_W-1:0]        req_opcode = '0;
   logic [REQUEST_BYTES_W-1:0] req_request_bytes = '0;
   logic [NODE_INDEX_W-1:0]    req_node_index = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_status;
   logic [RESULT_NODE_W-1:0]   rsp_result_node;
   logic [RESULT_PAGES_W-1:0]  rsp_result_pages;
   logic [BYTE_OFFSET_W-1:0]   rsp_byte_offset;

   logic [RESULT_PAGES_W-1:0] span_free [NODES];
   bpa_result_type            pending_grants [$];
   bpa_result_type            oldest_grant;
   int unsigned               live_nodes [$];
   int                        failures = 0;
   int                        quiet_cycles = 0;
   bit                        burst_mode = 1'b0;

   buddy_page_allocator i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_request_bytes (req_request_bytes),
      .req_node_index    (req_node_index),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_result_node   (rsp_result_node),
      .rsp_result_pages  (rsp_result_pages),
      .rsp_byte_offset   (rsp_byte_offset)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- tree predictor ----------------

   function automatic int unsigned node_depth(int unsigned n);
      int unsigned d = 0;
      int unsigned v = n + 1;
      while (v > 1) begin
         v >>= 1;
         d++;
      end
      return d;
   endfunction

   function automatic logic [RESULT_PAGES_W-1:0] node_pages(int unsigned n);
      return RESULT_PAGES_W'(PAGES >> node_depth(n));
   endfunction

   function automatic logic [BYTE_OFFSET_W-1:0] node_base(int unsigned n);
      int unsigned d   = node_depth(n);
      int unsigned pos = n + 1 - (1 << d);
      return BYTE_OFFSET_W'((pos * (PAGES >> d)) << SHIFT);
   endfunction

   function automatic void refold_node(int unsigned n);
      int unsigned               l = 2 * n + 1;
      logic [RESULT_PAGES_W-1:0] half, a, b;
      if (l + 1 >= NODES) return;
      half = node_pages(l);
      a    = span_free[l];
      b    = span_free[l + 1];
      if (a == half && b == half) span_free[n] = half << 1;
      else span_free[n] = (a >= b) ? a : b;
   endfunction

   function automatic void refold_path(int unsigned n);
      while (n != 0) begin
         n = (n - 1) >> 1;
         refold_node(n);
      end
   endfunction

   function automatic bpa_result_type granted(int unsigned n);
      bpa_result_type g;
      g.status       = STATUS_DONE;
      g.result_node  = RESULT_NODE_W'(n);
      g.result_pages = node_pages(n);
      g.byte_offset  = node_base(n);
      return g;
   endfunction

   function automatic bpa_result_type predict_grant(bpa_op_type op,
         logic [REQUEST_BYTES_W-1:0] bytes, logic [NODE_INDEX_W-1:0] node);
      bpa_result_type  refused = '0;
      longint unsigned want_pages;
      longint unsigned block = 1;
      int unsigned     n = 0;
      int unsigned     span = PAGES;
      int unsigned     idx = node;
      int unsigned     l, parent;
      refused.status = STATUS_REFUSED;
      if (op == OP_ALLOC) begin
         if (bytes == 0 || bytes > (PAGES << SHIFT)) return refused;
         want_pages = (longint'(bytes) + (1 << SHIFT) - 1) >> SHIFT;
         while (block < want_pages) block <<= 1;
         if (span_free[0] < block) return refused;
         while (span > block) begin
            l    = 2 * n + 1;
            n    = (span_free[l] >= span_free[l + 1]) ? l : l + 1;
            span >>= 1;
         end
         span_free[n] = '0;
         refold_path(n);
         return granted(n);
      end
      if (idx >= NODES) return refused;
      case (op)
         OP_FREE: begin
            span_free[idx] = node_pages(idx);
            refold_path(idx);
            return granted(idx);
         end
         OP_GROW: begin
            if (idx == 0 || idx[0] == 1'b0) return refused;
            if (span_free[idx + 1] != node_pages(idx + 1)) return refused;
            parent            = (idx - 1) >> 1;
            span_free[idx]    = node_pages(idx);
            span_free[parent] = '0;
            refold_path(parent);
            return granted(parent);
         end
         default: begin
            l = 2 * idx + 1;
            if (l >= NODES) return refused;
            span_free[l]     = '0;
            span_free[l + 1] = node_pages(l + 1);
            refold_node(idx);
            refold_path(idx);
            return granted(l);
         end
      endcase
   endfunction

   // ---------------- handshakes ----------------

   function automatic int unsigned pick_gap();
      int unsigned r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input bpa_op_type op, input logic [REQUEST_BYTES_W-1:0] bytes,
         input logic [NODE_INDEX_W-1:0] node, output bpa_result_type grant);
      int unsigned gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_request_bytes <= bytes;
      req_node_index    <= node;
      do @(posedge clock); while (!req_ready);
      grant = predict_grant(op, bytes, node);
      pending_grants.push_back(grant);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned run;
      @(posedge clock);
      forever begin
         if (burst_mode) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            run = $urandom_range(1, 24);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            run = pick_gap();
            if (run > 0) begin
               rsp_ready <= 1'b0;
               repeat (run) @(posedge clock);
            end
         end
      end
   end

   task automatic check_field(string label, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: response with no request outstanding, expected none actual node %0d",
                     $time, rsp_result_node);
            failures++;
         end else begin
            oldest_grant = pending_grants.pop_front();
            check_field("status", oldest_grant.status, rsp_status);
            check_field("result_node", oldest_grant.result_node, rsp_result_node);
            check_field("result_pages", oldest_grant.result_pages, rsp_result_pages);
            check_field("byte_offset", oldest_grant.byte_offset, rsp_byte_offset);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("buddy_page_allocator: mismatch");
      $finish;
   end

   // ---------------- tests ----------------

   task automatic test_request_size();
      bpa_result_type g;
      send_request(OP_ALLOC, 25'd0, '0, g);
      send_request(OP_ALLOC, 25'd16777217, '0, g);
      send_request(OP_ALLOC, 25'h1FF_FFFF, 13'h1FFF, g);
      send_request(OP_ALLOC, 25'd16777216, '0, g);
      send_request(OP_ALLOC, 25'd1, '0, g);
      send_request(OP_FREE, '0, 13'd0, g);
   endtask

   task automatic test_node_range();
      bpa_result_type g;
      send_request(OP_FREE, '0, 13'd8191, g);
      send_request(OP_GROW, '0, 13'd8191, g);
      send_request(OP_SHRINK, 25'h1FF_FFFF, 13'd8191, g);
   endtask

   task automatic test_alloc_sizes();
      bpa_result_type g;
      send_request(OP_ALLOC, 25'd1, '0, g);
      send_request(OP_ALLOC, 25'd4097, '0, g);
      send_request(OP_ALLOC, 25'd8388608, '0, g);
   endtask

   task automatic test_grow();
      bpa_result_type g;
      send_request(OP_GROW, '0, 13'd0, g);
      send_request(OP_GROW, '0, 13'd2, g);
      send_request(OP_GROW, '0, 13'd4095, g);
      send_request(OP_GROW, '0, 13'd2047, g);
   endtask

   task automatic test_shrink();
      bpa_result_type g;
      send_request(OP_SHRINK, '0, 13'd8190, g);
      send_request(OP_SHRINK, '0, 13'd2, g);
   endtask

   task automatic test_unchecked_use();
      bpa_result_type g;
      send_request(OP_FREE, '0, 13'd6, g);
      send_request(OP_SHRINK, '0, 13'd100, g);
      send_request(OP_FREE, '0, 13'd2047, g);
      send_request(OP_FREE, '0, 13'd2048, g);
      send_request(OP_FREE, '0, 13'd5, g);
      send_request(OP_FREE, '0, 13'd201, g);
      send_request(OP_FREE, '0, 13'd8190, g);
   endtask

   task automatic test_random_traffic(int count);
      bpa_result_type             g;
      bpa_op_type                 op;
      logic [REQUEST_BYTES_W-1:0] bytes;
      logic [NODE_INDEX_W-1:0]    node;
      int unsigned                pick, k, r, order;
      bit                         tracked;
      for (int i = 0; i < count; i++) begin
         pick    = $urandom_range(0, 99);
         bytes   = REQUEST_BYTES_W'($urandom);
         node    = NODE_INDEX_W'($urandom);
         k       = (live_nodes.size() != 0) ? $urandom_range(0, live_nodes.size() - 1) : 0;
         tracked = 1'b1;
         if (pick < 40 || (pick < 85 && live_nodes.size() == 0)) begin
            op    = OP_ALLOC;
            r     = $urandom_range(0, 99);
            order = (r < 70) ? $urandom_range(0, 3) :
                    (r < 95) ? $urandom_range(4, 8) : $urandom_range(9, LEVELS);
            bytes = REQUEST_BYTES_W'($urandom_range(1, (1 << order) << SHIFT));
         end else if (pick < 85) begin
            op   = (pick < 65) ? OP_FREE : (pick < 75) ? OP_GROW : OP_SHRINK;
            node = NODE_INDEX_W'(live_nodes[k]);
         end else begin
            op      = bpa_op_type'(OPCODE_W'($urandom_range(0, 3)));
            tracked = 1'b0;
         end
         send_request(op, bytes, node, g);
         if (tracked && g.status == STATUS_DONE) begin
            case (op)
               OP_ALLOC: live_nodes.push_back(g.result_node);
               OP_FREE:  live_nodes.delete(k);
               default:  live_nodes[k] = g.result_node;
            endcase
         end
      end
   endtask

   initial begin
      for (int n = 0; n < NODES; n++) span_free[n] = node_pages(n);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_request_size();
      test_node_range();
      test_alloc_sizes();
      test_grow();
      test_shrink();
      test_unchecked_use();
      test_random_traffic(365);
      wait_idle();
      burst_mode = 1'b1;
      test_random_traffic(40);
      wait_idle();
      burst_mode = 1'b0;
      test_random_traffic(20);
      wait_idle();
      if (failures == 0) $display("buddy_page_allocator: match");
      else $display("buddy_page_allocator: mismatch");
      $finish;
   end

endmodule
